/* rtl/core/spmr_pkg.sv */
`timescale 1ns / 1ps

package spmr_pkg;

    localparam int ADC_BITS   = 10;
    localparam int COUNT_BITS = 16;
    localparam int SUM_BITS   = ADC_BITS + COUNT_BITS;
    localparam int SQ_BITS    = 2 * ADC_BITS + COUNT_BITS;
    localparam int RMS_BITS   = ADC_BITS + 3;
    localparam int CFG_BITS   = 16;

    // variance numerator n*q - s*s, scaled by 1024 before the root
    localparam int D_BITS     = COUNT_BITS + SQ_BITS;
    localparam int SQRT_PAD   = 10;
    localparam int X_BITS     = D_BITS + SQRT_PAD;
    localparam int ROOT_BITS  = X_BITS / 2;

    // square sum split into two halves for the count multiply
    localparam int Q_SPLIT    = SQ_BITS / 2;
    localparam int P_LO_BITS  = COUNT_BITS + Q_SPLIT;
    localparam int P_HI_BITS  = COUNT_BITS + SQ_BITS - Q_SPLIT;

    // divider widths, divisor is 2n
    localparam int DIV_BITS    = COUNT_BITS + 1;
    localparam int PED_A_BITS  = SUM_BITS + 2;
    localparam int PED_HI_BITS = PED_A_BITS - ADC_BITS;
    localparam int RMS_A_BITS  = ROOT_BITS + 1;
    localparam int RMS_HI_BITS = RMS_A_BITS - RMS_BITS;

    localparam logic [CFG_BITS-1:0] LOW_THRESH_RESET = 16'd90;

    typedef struct packed {
        logic [COUNT_BITS-1:0] event_count;
        logic [SUM_BITS-1:0]   value_sum;
        logic [SQ_BITS-1:0]    square_sum;
    } item_t;

    typedef struct packed {
        logic [ADC_BITS-1:0] pedestal;
        logic [RMS_BITS-1:0] rms_sixteenths;
        logic                never_seen;
        logic                low_count;
    } result_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] n;
        logic                  never_seen;
        logic                  low_count;
        logic                  ped_sat;
        logic [ADC_BITS-1:0]   pedestal;
        logic                  rms_sat;
    } side_t;

endpackage

/* rtl/core/spmr_front.sv */
`timescale 1ns / 1ps

module spmr_front
(
    input  logic                              clk,
    input  logic                              en,
    input  spmr_pkg::item_t                   item,
    input  logic [spmr_pkg::CFG_BITS-1:0]     low_thresh,
    output logic [spmr_pkg::X_BITS-1:0]       x,
    output spmr_pkg::side_t                   side,
    output logic [spmr_pkg::DIV_BITS-1:0]     ped_rem,
    output logic [spmr_pkg::ADC_BITS-1:0]     ped_low
);

    logic [spmr_pkg::P_LO_BITS-1:0]   p_lo_reg;
    logic [spmr_pkg::P_HI_BITS-1:0]   p_hi_reg;
    logic [spmr_pkg::D_BITS-1:0]      ss_reg;
    logic [spmr_pkg::PED_A_BITS-1:0]  a_ped_reg;
    logic [spmr_pkg::COUNT_BITS-1:0]  n0_reg;
    logic                             never0_reg;
    logic                             low0_reg;

    logic [spmr_pkg::X_BITS-1:0]      x_reg;
    spmr_pkg::side_t                  side_reg;
    logic [spmr_pkg::DIV_BITS-1:0]    ped_rem_reg;
    logic [spmr_pkg::ADC_BITS-1:0]    ped_low_reg;

    logic [spmr_pkg::P_LO_BITS-1:0]   p_lo_next;
    logic [spmr_pkg::P_HI_BITS-1:0]   p_hi_next;
    logic [spmr_pkg::D_BITS-1:0]      ss_next;
    logic [spmr_pkg::PED_A_BITS-1:0]  a_ped_next;
    logic [spmr_pkg::D_BITS-1:0]      nq;
    logic [spmr_pkg::D_BITS-1:0]      d;
    logic [spmr_pkg::PED_HI_BITS-1:0] ped_hi;
    logic [spmr_pkg::DIV_BITS-1:0]    ped_div;
    logic                             ped_sat;
    spmr_pkg::side_t                  side_next;

    always_comb
    begin
        p_lo_next = {{spmr_pkg::Q_SPLIT{1'b0}}, item.event_count}
                  * {{spmr_pkg::COUNT_BITS{1'b0}},
                     item.square_sum[spmr_pkg::Q_SPLIT-1:0]};
        p_hi_next = {{(spmr_pkg::P_HI_BITS-spmr_pkg::COUNT_BITS){1'b0}}, item.event_count}
                  * {{spmr_pkg::COUNT_BITS{1'b0}},
                     item.square_sum[spmr_pkg::SQ_BITS-1:spmr_pkg::Q_SPLIT]};
        ss_next   = {{spmr_pkg::SUM_BITS{1'b0}}, item.value_sum}
                  * {{spmr_pkg::SUM_BITS{1'b0}}, item.value_sum};
        a_ped_next = {1'b0, item.value_sum, 1'b0}
                   + {{(spmr_pkg::PED_A_BITS-spmr_pkg::COUNT_BITS){1'b0}}, item.event_count};

        nq = {p_hi_reg, {spmr_pkg::Q_SPLIT{1'b0}}}
           + {{(spmr_pkg::D_BITS-spmr_pkg::P_LO_BITS){1'b0}}, p_lo_reg};
        d  = (nq >= ss_reg) ? (nq - ss_reg) : '0;

        ped_hi  = a_ped_reg[spmr_pkg::PED_A_BITS-1:spmr_pkg::ADC_BITS];
        ped_div = {n0_reg, 1'b0};
        ped_sat = ped_hi >= {{(spmr_pkg::PED_HI_BITS-spmr_pkg::DIV_BITS){1'b0}}, ped_div};

        side_next.n          = n0_reg;
        side_next.never_seen = never0_reg;
        side_next.low_count  = low0_reg;
        side_next.ped_sat    = ped_sat;
        side_next.pedestal   = '0;
        side_next.rms_sat    = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_lo_reg    <= p_lo_next;
            p_hi_reg    <= p_hi_next;
            ss_reg      <= ss_next;
            a_ped_reg   <= a_ped_next;
            n0_reg      <= item.event_count;
            never0_reg  <= (item.event_count == '0);
            low0_reg    <= (item.event_count < low_thresh);

            x_reg       <= {d, {spmr_pkg::SQRT_PAD{1'b0}}};
            side_reg    <= side_next;
            ped_rem_reg <= ped_sat ? '0 : ped_hi[spmr_pkg::DIV_BITS-1:0];
            ped_low_reg <= a_ped_reg[spmr_pkg::ADC_BITS-1:0];
        end
    end

    assign x       = x_reg;
    assign side    = side_reg;
    assign ped_rem = ped_rem_reg;
    assign ped_low = ped_low_reg;

endmodule

/* rtl/core/spmr_sqrt_cell.sv */
`timescale 1ns / 1ps

module spmr_sqrt_cell
(
    input  logic                                 clk,
    input  logic                                 en,
    input  logic [spmr_pkg::X_BITS-1:0]          x_in,
    input  logic [spmr_pkg::ROOT_BITS+1:0]       rem_in,
    input  logic [spmr_pkg::ROOT_BITS-1:0]       root_in,
    output logic [spmr_pkg::X_BITS-1:0]          x_out,
    output logic [spmr_pkg::ROOT_BITS+1:0]       rem_out,
    output logic [spmr_pkg::ROOT_BITS-1:0]       root_out
);

    logic [spmr_pkg::X_BITS-1:0]    x_reg;
    logic [spmr_pkg::ROOT_BITS+1:0] rem_reg;
    logic [spmr_pkg::ROOT_BITS-1:0] root_reg;

    logic [spmr_pkg::ROOT_BITS+1:0] rem_t;
    logic [spmr_pkg::ROOT_BITS+1:0] trial;
    logic                           ge;

    always_comb
    begin
        rem_t = {rem_in[spmr_pkg::ROOT_BITS-1:0], x_in[spmr_pkg::X_BITS-1 -: 2]};
        trial = {root_in, 2'b01};
        ge    = rem_t >= trial;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= {x_in[spmr_pkg::X_BITS-3:0], 2'b00};
            rem_reg  <= ge ? (rem_t - trial) : rem_t;
            root_reg <= {root_in[spmr_pkg::ROOT_BITS-2:0], ge};
        end
    end

    assign x_out    = x_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule

/* rtl/core/spmr_div_cell.sv */
`timescale 1ns / 1ps

module spmr_div_cell
#(
    parameter int K  = 10,
    parameter int VW = 17
)
(
    input  logic          clk,
    input  logic          en,
    input  logic [VW-1:0] rem_in,
    input  logic [K-1:0]  low_in,
    input  logic [VW-1:0] div,
    output logic [VW-1:0] rem_out,
    output logic [K-1:0]  low_out
);

    logic [VW-1:0] rem_reg;
    logic [K-1:0]  low_reg;
    logic [VW:0]   rt;
    logic [VW:0]   diff;
    logic          ge;

    always_comb
    begin
        rt   = {rem_in, low_in[K-1]};
        diff = rt - {1'b0, div};
        ge   = rt >= {1'b0, div};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= ge ? diff[VW-1:0] : rt[VW-1:0];
            low_reg <= {low_in[K-2:0], ge};
        end
    end

    assign rem_out = rem_reg;
    assign low_out = low_reg;

endmodule

/* rtl/core/strip_pedestal_mean_rms.sv */
`timescale 1ns / 1ps

// strip pedestal mean and rms
// item channel (item_valid / item_ready / item) takes one strip's event count,
// sum and sum of squares per beat; result channel (result_valid / result_ready /
// result) returns pedestal, rms in sixteenths, never_seen and low_count.
// cfg channel (cfg_valid / cfg_ready / cfg_data) writes the low-count threshold,
// always ready; write it only while the block is idle.
// one beat in and one beat out per cycle while results are taken, fully pipelined.
// the path from item beat to result: the multiply and subtract registers,
// 31 square root cells (one root bit each), 13 divider cells for the
// rms (one quotient bit each); the pedestal divider runs beside the root cells.
// when the receiver stalls a held result freezes the whole pipeline and
// item_ready drops in the same cycle; no beat is lost or repeated.
// reset empties the pipeline and sets the low-count threshold to 90.
module strip_pedestal_mean_rms
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  spmr_pkg::item_t               item,
    output logic                          result_valid,
    input  logic                          result_ready,
    output spmr_pkg::result_t             result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [spmr_pkg::CFG_BITS-1:0] cfg_data
);

    localparam int RW = spmr_pkg::ROOT_BITS;
    localparam int AB = spmr_pkg::ADC_BITS;
    localparam int RB = spmr_pkg::RMS_BITS;
    localparam int DB = spmr_pkg::DIV_BITS;
    localparam int L  = RW + RB;

    logic                          en;
    logic [spmr_pkg::CFG_BITS-1:0] low_thresh_reg;
    logic [L+1:0]                  vld_reg;

    logic [spmr_pkg::X_BITS-1:0]   sq_x    [0:RW];
    logic [RW+1:0]                 sq_rem  [0:RW];
    logic [RW-1:0]                 sq_root [0:RW];

    logic [DB-1:0]                 pd_rem  [0:AB];
    logic [AB-1:0]                 pd_low  [0:AB];
    logic [DB-1:0]                 rm_rem  [0:RB];
    logic [RB-1:0]                 rm_low  [0:RB];

    spmr_pkg::side_t               side_s    [0:L];
    spmr_pkg::side_t               side_next [0:L-1];
    spmr_pkg::side_t               side_reg  [0:L-1];

    logic [spmr_pkg::RMS_A_BITS-1:0]  rms_a;
    logic [spmr_pkg::RMS_HI_BITS-1:0] rms_hi;
    logic                             rms_sat;
    spmr_pkg::side_t                  side_end;

    assign en         = !vld_reg[L+1] || result_ready;
    assign item_ready = en;
    assign cfg_ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_thresh_reg <= spmr_pkg::LOW_THRESH_RESET;
            vld_reg        <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                low_thresh_reg <= cfg_data;
            end
            if (en)
            begin
                vld_reg <= {vld_reg[L:0], item_valid};
            end
        end
    end

    spmr_front u_front
    (
        .clk        (clk),
        .en         (en),
        .item       (item),
        .low_thresh (low_thresh_reg),
        .x          (sq_x[0]),
        .side       (side_s[0]),
        .ped_rem    (pd_rem[0]),
        .ped_low    (pd_low[0])
    );

    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;

    genvar i;
    generate
        for (i = 0; i < RW; i++)
        begin : g_sqrt
            spmr_sqrt_cell u_cell
            (
                .clk      (clk),
                .en       (en),
                .x_in     (sq_x[i]),
                .rem_in   (sq_rem[i]),
                .root_in  (sq_root[i]),
                .x_out    (sq_x[i+1]),
                .rem_out  (sq_rem[i+1]),
                .root_out (sq_root[i+1])
            );
        end

        for (i = 0; i < AB; i++)
        begin : g_ped
            spmr_div_cell #(.K(AB), .VW(DB)) u_cell
            (
                .clk     (clk),
                .en      (en),
                .rem_in  (pd_rem[i]),
                .low_in  (pd_low[i]),
                .div     ({side_s[i].n, 1'b0}),
                .rem_out (pd_rem[i+1]),
                .low_out (pd_low[i+1])
            );
        end

        for (i = 0; i < RB; i++)
        begin : g_rms
            spmr_div_cell #(.K(RB), .VW(DB)) u_cell
            (
                .clk     (clk),
                .en      (en),
                .rem_in  (rm_rem[i]),
                .low_in  (rm_low[i]),
                .div     ({side_s[RW+i].n, 1'b0}),
                .rem_out (rm_rem[i+1]),
                .low_out (rm_low[i+1])
            );
        end

        for (i = 0; i < L; i++)
        begin : g_side
            always_comb
            begin
                side_next[i] = side_s[i];
                if (i == AB)
                begin
                    side_next[i].pedestal = side_s[i].ped_sat ? '1 : pd_low[AB];
                end
                if (i == RW)
                begin
                    side_next[i].rms_sat = rms_sat;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    side_reg[i] <= side_next[i];
                end
            end

            assign side_s[i+1] = side_reg[i];
        end
    endgenerate

    // rms divider set-up: (root + n) / 2n
    always_comb
    begin
        rms_a   = {1'b0, sq_root[RW]}
                + {{(spmr_pkg::RMS_A_BITS-spmr_pkg::COUNT_BITS){1'b0}}, side_s[RW].n};
        rms_hi  = rms_a[spmr_pkg::RMS_A_BITS-1:RB];
        rms_sat = rms_hi >= {{(spmr_pkg::RMS_HI_BITS-DB){1'b0}}, side_s[RW].n, 1'b0};
    end

    assign rm_rem[0] = rms_sat ? '0 : rms_hi[DB-1:0];
    assign rm_low[0] = rms_a[RB-1:0];

    assign side_end = side_s[L];

    always_comb
    begin
        result.never_seen     = side_end.never_seen;
        result.low_count      = side_end.low_count;
        result.pedestal       = side_end.never_seen ? '0 : side_end.pedestal;
        result.rms_sixteenths = side_end.never_seen ? '0 :
                                (side_end.rms_sat ? '1 : rm_low[RB]);
    end

    assign result_valid = vld_reg[L+1];

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> vld_reg[0])
        else $error("accepted beat did not enter the pipeline");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");

    a_never_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.never_seen |->
            result.pedestal == '0 && result.rms_sixteenths == '0)
        else $error("never seen strip with nonzero result");

    a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |-> !item_ready)
        else $error("item taken while result stalled");

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    localparam int LATENCY = 46;
    localparam int N_RANDOM = 1250;
    localparam int DIR_ROWS = 14;

    logic clk;
    logic rst_n;
    logic item_valid;
    logic item_ready;
    spmr_pkg::item_t item;
    logic result_valid;
    logic result_ready;
    spmr_pkg::result_t result;
    logic cfg_valid;
    logic cfg_ready;
    logic [spmr_pkg::CFG_BITS-1:0] cfg_data;

    logic [spmr_pkg::CFG_BITS-1:0] low_thresh_q;
    spmr_pkg::result_t pending_results[$];
    int n_fail;
    int n_checked;
    int n_sent;
    bit hold_rx;
    bit rx_hold_done;

    strip_pedestal_mean_rms i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("strip_pedestal_mean_rms verification failed");
        $finish;
    end

    function automatic logic [63:0] int_sqrt(logic [127:0] x);
        logic [63:0] r;
        logic [63:0] c;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            c = r | (64'd1 << i);
            if ({64'd0, c} * {64'd0, c} <= x)
                r = c;
        end
        return r;
    endfunction

    function automatic spmr_pkg::result_t strip_stats(spmr_pkg::item_t it,
                                                      logic [spmr_pkg::CFG_BITS-1:0] min_ev);
        spmr_pkg::result_t r;
        logic [127:0] nq;
        logic [127:0] ss;
        logic [127:0] x;
        logic [63:0] n;
        logic [63:0] s;
        logic [63:0] ped;
        logic [63:0] rms;
        n = 64'(it.event_count);
        s = 64'(it.value_sum);
        r = '0;
        if (n == 0)
            r.never_seen = 1'b1;
        else
        begin
            nq = 128'(n) * 128'(it.square_sum);
            ss = 128'(s) * 128'(s);
            ped = (64'd2 * s + n) / (64'd2 * n);
            r.pedestal = (ped > 64'd1023) ? '1 : ped[spmr_pkg::ADC_BITS-1:0];
            if (ss <= nq)
            begin
                x = (nq - ss) << 10;
                rms = (int_sqrt(x) + n) / (64'd2 * n);
                r.rms_sixteenths = (rms > 64'd8191) ? '1 : rms[spmr_pkg::RMS_BITS-1:0];
            end
        end
        r.low_count = it.event_count < min_ev;
        return r;
    endfunction

    function automatic int gap_len();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) :
               (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3));
    endfunction

    // leaves valid high after the beat; callers drop it before any idle time
    task automatic send_strip(spmr_pkg::item_t it, spmr_pkg::result_t exp_r, bit use_exp);
        item_valid <= 1'b1;
        item <= it;
        pending_results.push_back(use_exp ? exp_r : strip_stats(it, low_thresh_q));
        do
            @(posedge clk);
        while (!item_ready);
        n_sent++;
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_low_thresh(logic [spmr_pkg::CFG_BITS-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        low_thresh_q = v;
    endtask

    function automatic spmr_pkg::item_t rand_strip(logic [spmr_pkg::CFG_BITS-1:0] min_ev);
        spmr_pkg::item_t it;
        logic [63:0] n;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] s;
        logic [63:0] q;
        case ($urandom_range(0, 9))
            0:
            begin
                it.event_count = 16'($urandom);
                it.value_sum = 26'({$urandom, $urandom});
                it.square_sum = 36'({$urandom, $urandom});
            end
            1:
            begin
                it.event_count = 16'(min_ev) + 16'($urandom_range(0, 2)) - 16'd1;
                it.value_sum = 26'($urandom_range(0, 5000));
                it.square_sum = 36'($urandom_range(0, 500000));
            end
            default:
            begin
                n = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(1, 65535))
                                                 : 64'($urandom_range(1, 300));
                a = 64'($urandom_range(0, 1023));
                b = 64'($urandom_range(0, 32'(64'd1023 - a)));
                s = n * a + (($urandom_range(0, 1) == 1) ?
                             64'($urandom_range(0, 32'(n * b))) : 64'd0);
                q = (s * s) / n + 64'($urandom_range(0, 32'd1 << $urandom_range(0, 20)));
                if (q > 64'd68584278015)
                    q = 64'd68584278015;
                it.event_count = n[15:0];
                it.value_sum = s[25:0];
                it.square_sum = q[35:0];
            end
        endcase
        return it;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%t unexpected result %h", $time, result);
                n_fail++;
            end
            else
            begin
                spmr_pkg::result_t e;
                e = pending_results.pop_front();
                n_checked++;
                if (e.pedestal !== result.pedestal)
                begin
                    $display("%t pedestal exp %0d act %0d", $time, e.pedestal, result.pedestal);
                    n_fail++;
                end
                if (e.rms_sixteenths !== result.rms_sixteenths)
                begin
                    $display("%t rms exp %0d act %0d", $time, e.rms_sixteenths,
                             result.rms_sixteenths);
                    n_fail++;
                end
                if (e.never_seen !== result.never_seen)
                begin
                    $display("%t never_seen exp %b act %b", $time, e.never_seen,
                             result.never_seen);
                    n_fail++;
                end
                if (e.low_count !== result.low_count)
                begin
                    $display("%t low_count exp %b act %b", $time, e.low_count,
                             result.low_count);
                    n_fail++;
                end
            end
        end
    end

    // receiver with random stalls
    initial
    begin
        int g;
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_rx && !rx_hold_done)
            begin
                result_ready <= 1'b0;
                repeat (200) @(posedge clk);
                rx_hold_done = 1'b1;
            end
            g = gap_len();
            if (g > 0)
            begin
                result_ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
            result_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    initial
    begin
        spmr_pkg::item_t dir_items[DIR_ROWS];
        spmr_pkg::result_t dir_exp[DIR_ROWS];
        bit dir_has[DIR_ROWS];
        logic [spmr_pkg::CFG_BITS-1:0] cfg_set[5];
        int g;
        n_fail = 0;
        n_checked = 0;
        n_sent = 0;
        hold_rx = 1'b0;
        rx_hold_done = 1'b0;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        low_thresh_q = spmr_pkg::LOW_THRESH_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        dir_items[0] = '{16'd0, 26'd0, 36'd0};
        dir_exp[0] = '{10'd0, 13'd0, 1'b1, 1'b1}; dir_has[0] = 1;
        dir_items[1] = '{16'd0, '1, '1};
        dir_exp[1] = '{10'd0, 13'd0, 1'b1, 1'b1}; dir_has[1] = 1;
        dir_items[2] = '{16'd1, 26'd0, 36'd0};
        dir_exp[2] = '{10'd0, 13'd0, 1'b0, 1'b1}; dir_has[2] = 1;
        dir_items[3] = '{16'd1, 26'd1023, 36'd1046529};
        dir_exp[3] = '{10'd1023, 13'd0, 1'b0, 1'b1}; dir_has[3] = 1;
        dir_items[4] = '{16'd100, 26'd5000, 36'd250000};
        dir_exp[4] = '{10'd50, 13'd0, 1'b0, 1'b0}; dir_has[4] = 1;
        dir_items[5] = '{16'd90, 26'd0, 36'd0};
        dir_exp[5] = '{10'd0, 13'd0, 1'b0, 1'b0}; dir_has[5] = 1;
        dir_items[6] = '{16'd89, 26'd0, 36'd0};
        dir_exp[6] = '{10'd0, 13'd0, 1'b0, 1'b1}; dir_has[6] = 1;
        // negative variance
        dir_items[7] = '{16'd10, 26'd1000, 36'd5};
        dir_exp[7] = '{10'd100, 13'd0, 1'b0, 1'b1}; dir_has[7] = 1;
        // oversized mean
        dir_items[8] = '{16'd1, '1, '1};
        dir_exp[8] = '{10'd1023, 13'd0, 1'b0, 1'b1}; dir_has[8] = 1;
        // oversized rms
        dir_items[9] = '{16'd2, 26'd0, '1};
        dir_exp[9] = '0; dir_has[9] = 0;
        dir_items[10] = '{'1, '1, '1};
        dir_exp[10] = '0; dir_has[10] = 0;
        dir_items[11] = '{16'd3, 26'd4, 36'd6};
        dir_exp[11] = '0; dir_has[11] = 0;
        dir_items[12] = '{16'd65535, 26'd67042305, 36'd68584278015};
        dir_exp[12] = '0; dir_has[12] = 0;
        dir_items[13] = '{16'd200, 26'd100000, 36'd50050000};
        dir_exp[13] = '0; dir_has[13] = 0;

        for (int i = 0; i < DIR_ROWS; i++)
            send_strip(dir_items[i], dir_exp[i], dir_has[i]);

        cfg_set[0] = 16'd0;
        cfg_set[1] = 16'hffff;
        cfg_set[2] = 16'd1;
        cfg_set[3] = 16'h5555;
        cfg_set[4] = 16'haaaa;
        for (int ph = 0; ph < 5; ph++)
        begin
            write_low_thresh(cfg_set[ph]);
            send_strip('{16'd0, 26'd0, 36'd0}, '0, 0);
            send_strip('{cfg_set[ph], 26'd0, 36'd0}, '0, 0);
            for (int k = 0; k < N_RANDOM / 5; k++)
            begin
                if (ph == 1 && k == 20)
                    hold_rx = 1'b1;
                if (ph == 2 && k == 100)
                    drain();
                g = (ph == 1 && k < 120) ? 0 : gap_len();
                if (g > 0)
                begin
                    item_valid <= 1'b0;
                    repeat (g) @(posedge clk);
                end
                send_strip(rand_strip(low_thresh_q), '0, 0);
            end
        end

        drain();
        $display("strips sent %0d, results checked %0d, five threshold settings",
                 n_sent, n_checked);
        $display("covered never seen, negative variance, saturation, long stall");
        if (n_fail == 0 && pending_results.size() == 0)
            $display("strip_pedestal_mean_rms verification clean");
        else
            $display("strip_pedestal_mean_rms verification failed");
        $finish;
    end

endmodule
